>>> sv/iem_pkg.sv
package iem_pkg;

    // Phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SLAVE = 3'd1;
    localparam logic [2:0] PH_REG   = 3'd2;
    localparam logic [2:0] PH_WRITE = 3'd3;
    localparam logic [2:0] PH_WAIT  = 3'd4;
    localparam logic [2:0] PH_READ  = 3'd5;

    // Bus event codes
    localparam logic [2:0] EV_START  = 3'd0;
    localparam logic [2:0] EV_RSTART = 3'd1;
    localparam logic [2:0] EV_AWR    = 3'd2;
    localparam logic [2:0] EV_ARD    = 3'd3;
    localparam logic [2:0] EV_DWR    = 3'd4;
    localparam logic [2:0] EV_DRD    = 3'd5;
    localparam logic [2:0] EV_STOP   = 3'd6;
    localparam logic [2:0] EV_OTHER  = 3'd7;

    // Note codes
    localparam logic [1:0] NOTE_NONE  = 2'd0;
    localparam logic [1:0] NOTE_NAMED = 2'd1;
    localparam logic [1:0] NOTE_VALUE = 2'd2;
    localparam logic [1:0] NOTE_WARN  = 2'd3;

    // Expander register map
    localparam logic [7:0] REG_INPUT    = 8'h00;
    localparam logic [7:0] REG_OUTPUT   = 8'h01;
    localparam logic [7:0] REG_POLARITY = 8'h02;
    localparam logic [7:0] REG_CONFIG   = 8'h03;

    // Configuration register indexes and reset values
    localparam logic CFG_FIRST_ADDR  = 1'b0;
    localparam logic CFG_SECOND_ADDR = 1'b1;
    localparam logic [6:0] FIRST_ADDR_RST  = 7'h20;
    localparam logic [6:0] SECOND_ADDR_RST = 7'h21;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] pointer;
        logic [7:0] port;
    } iem_state_t;

    typedef struct packed {
        logic [1:0] note_kind;
        logic [7:0] register_index;
        logic [7:0] note_byte;
        logic       port_changed;
    } iem_note_t;

endpackage

>>> sv/iem_step.sv
module iem_step
    import iem_pkg::*;
(
    input  iem_state_t cur,
    input  logic [2:0] kind,
    input  logic [7:0] event_byte,
    input  logic [6:0] first_addr,
    input  logic [6:0] second_addr,
    output iem_state_t nxt,
    output iem_note_t  note
);

    logic is_addr;
    logic addr_ok;

    assign is_addr = (kind == EV_AWR) || (kind == EV_ARD);
    assign addr_ok = (event_byte == {1'b0, first_addr})
                  || (event_byte == {1'b0, second_addr});

    always_comb
    begin
        nxt  = cur;
        note = '0;
        unique case (cur.phase)
            PH_SLAVE:
            begin
                if (is_addr)
                begin
                    if (addr_ok)
                    begin
                        nxt.phase = PH_REG;
                    end
                    else
                    begin
                        note.note_kind = NOTE_WARN;
                        note.note_byte = event_byte;
                        nxt.phase      = PH_IDLE;
                    end
                end
            end
            PH_REG:
            begin
                if (is_addr)
                begin
                    if (!addr_ok)
                    begin
                        note.note_kind = NOTE_WARN;
                        note.note_byte = event_byte;
                        nxt.phase      = PH_IDLE;
                    end
                end
                else if (kind == EV_DWR)
                begin
                    nxt.pointer = event_byte;
                    nxt.phase   = PH_WRITE;
                    if (event_byte <= REG_CONFIG)
                    begin
                        note.note_kind      = NOTE_NAMED;
                        note.register_index = event_byte;
                    end
                end
            end
            PH_WRITE, PH_READ:
            begin
                if (kind == EV_RSTART && cur.phase == PH_WRITE)
                begin
                    nxt.phase = PH_WAIT;
                end
                else if ((kind == EV_DWR && cur.phase == PH_WRITE)
                      || (kind == EV_DRD && cur.phase == PH_READ))
                begin
                    // data byte classified by the latched pointer
                    if (cur.pointer <= REG_CONFIG)
                    begin
                        note.note_kind      = NOTE_VALUE;
                        note.register_index = cur.pointer;
                        note.note_byte      = event_byte;
                        if (cur.pointer == REG_OUTPUT)
                        begin
                            nxt.port          = event_byte;
                            note.port_changed = 1'b1;
                        end
                    end
                end
                else if (kind == EV_STOP)
                begin
                    nxt.phase = PH_IDLE;
                end
            end
            PH_WAIT:
            begin
                if (kind == EV_ARD)
                begin
                    nxt.phase = PH_READ;
                end
            end
            default:
            begin
                // idle, and the unused codes
                nxt.phase = (kind == EV_START) ? PH_SLAVE : PH_IDLE;
            end
        endcase
    end

endmodule

>>> sv/i2c_io_expander_transaction_monitor.sv
// Each accepted word is held in the input register and then in the result register, which shows its result word.
// Throughput: one word per cycle; the result register stalls only when it is full and m_tready
// is low, and the input register then stalls as well once it holds a word.
// Reset (rst_n low, asynchronous): phase idle, pointer and port level zero,
// both pipeline stages empty, device addresses back to 0x20 and 0x21.
module i2c_io_expander_transaction_monitor
    import iem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wdata,
    // event words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] event_byte
    input  logic [2:0]  s_tuser,    // [2:0] kind
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] register_index, [15:8] note_byte,
                                    // [16] port_changed, [24:17] port_level,
                                    // [27:25] phase_now, [31:28] zero
    output logic [1:0]  m_tuser     // [1:0] note_kind
);

    logic [6:0] first_addr_reg;
    logic [6:0] second_addr_reg;

    // input stage
    logic       in_valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] byte_reg;

    // tracker state and result stage
    iem_state_t state_reg;
    iem_state_t state_next;
    iem_note_t  note_next;
    iem_note_t  note_reg;
    logic       out_valid_reg;

    logic advance;
    logic in_take;

    // result register frees up when empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_addr_reg  <= FIRST_ADDR_RST;
            second_addr_reg <= SECOND_ADDR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FIRST_ADDR:  first_addr_reg  <= cfg_wdata;
                CFG_SECOND_ADDR: second_addr_reg <= cfg_wdata;
                default:         first_addr_reg  <= first_addr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= s_tuser;
            byte_reg <= s_tdata;
        end
    end

    // phase machine and classification, one event per pass
    iem_step u_step (
        .cur         (state_reg),
        .kind        (kind_reg),
        .event_byte  (byte_reg),
        .first_addr  (first_addr_reg),
        .second_addr (second_addr_reg),
        .nxt         (state_next),
        .note        (note_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            note_reg <= note_next;
        end
    end

    // state_reg holds the state after the event in the result register
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = note_reg.note_kind;
    assign m_tdata  = {4'b0000, state_reg.phase, state_reg.port,
                       note_reg.port_changed, note_reg.note_byte,
                       note_reg.register_index};

`ifndef ASSERT_OFF
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase <= PH_READ)
        else $error("phase code out of range");

    a_port_change: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && note_reg.port_changed) |->
        (note_reg.note_kind == NOTE_VALUE && note_reg.register_index == REG_OUTPUT
         && state_reg.port == note_reg.note_byte))
        else $error("port change without an output register value");

    a_warn_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && note_reg.note_kind == NOTE_WARN) |-> (state_reg.phase == PH_IDLE))
        else $error("address warning did not return to idle");

    a_named_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && note_reg.note_kind == NOTE_NAMED) |->
        (state_reg.phase == PH_WRITE && state_reg.pointer == note_reg.register_index))
        else $error("register named outside write phase");

    a_port_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(state_reg.port) |-> (out_valid_reg && note_reg.port_changed))
        else $error("port level moved without a port change note");
`endif

endmodule
